/* rtl/sin_pkg.sv */
// Package for the shuffled index navigator: payload structs, command, mode
// and register codes, sequencer states. No dependencies.
package sin_pkg;

	localparam int SIN_MAX_ITEMS = 1024;
	localparam int CNT_W = 11;     // width of image_count and of internal indexes
	localparam int POS_W = 10;     // width of the reported position
	localparam int AMT_W = 16;
	localparam int CMD_W = 3;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam int LFSR_W = 16;

	localparam logic [CMD_W-1:0] CMD_FWD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BACK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REPEAT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_JUMP_FWD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_JUMP_BACK = 3'd4;
	localparam logic [CMD_W-1:0] CMD_JUMP_TO = 3'd5;

	localparam logic [MODE_W-1:0] MODE_SEQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd1;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [AMT_W-1:0] amount;
	} nav_in_t;

	typedef struct packed {
		logic [POS_W-1:0] current_position;
		logic             accepted;
	} nav_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_MUL,
		ST_RD,
		ST_WA,
		ST_WB,
		ST_DRAW,
		ST_DATA,
		ST_REM
	} state_t;

endpackage

/* rtl/sin_order_mem.sv */
// Permutation table: one write port, two registered read ports.
// Depends on nothing but its parameters.
module sin_order_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [AW-1:0] rdata_a,
	output logic [AW-1:0] rdata_b
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/sin_urem.sv */
// Bit-serial restoring remainder, one dividend bit per cycle.
// Depends on sin_pkg for the default width.
module sin_urem import sin_pkg::*; #(
	parameter int W = CNT_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] rem
);

	localparam int NW = $clog2(W + 1);

	logic [W-1:0]  dvd_q;
	logic [W-1:0]  div_q;
	logic [W-1:0]  acc_q;
	logic [NW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          ge;

	assign shifted = {acc_q, dvd_q[W-1]};
	assign ge = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= NW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			acc_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			// partial remainder stays below the divisor, so W bits suffice
			acc_q <= ge ? W'(shifted - {1'b0, div_q}) : W'(shifted);
		end
	end

	assign done = done_q;
	assign rem = acc_q;

endmodule

/* rtl/shuffled_index_navigator.sv */
// Shuffled index navigator top: command decode, sequencer, LFSR, config regs.
// Depends on sin_pkg, sin_order_mem, sin_urem.
// Jumps and in-range sequential steps strobe the result in the cycle after the
// transfer; a sequential step from past the count goes through the serial remainder.
// Table steps pass through the DRAW and DATA states; a step that finds the table invalid
// first rebuilds it (fill sweep, then MUL, RD, WA, WB per swap on the single write port).
// One command at a time; results cannot be stalled. Reset clears all control state;
// table contents stay undefined until a rebuild writes them.
module shuffled_index_navigator import sin_pkg::*; #(
	parameter int MAX_ITEMS = SIN_MAX_ITEMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  nav_in_t               command,
	output logic                  result_valid,
	output nav_out_t              result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int PW = LFSR_W + CNT_W;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  pos_q;
	logic              back_q;
	logic              dir_q;
	logic              valid_q;
	logic [CNT_W-1:0]  cursor_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  p_q;
	logic [PW-1:0]     prod_q;
	logic              done_q;
	logic              acc_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr_a;
	logic [AW-1:0] mem_raddr_b;
	logic [AW-1:0] mem_rdata_a;
	logic [AW-1:0] mem_rdata_b;

	logic             rem_start;
	logic [CNT_W-1:0] rem_dividend;
	logic             rem_done;
	logic [CNT_W-1:0] rem_value;

	// command decode
	logic             accept;
	logic             is_step;
	logic             step_back;
	logic             table_mode;
	logic [CNT_W:0]   fwd_sum;
	logic [CNT_W-1:0] back_dif;
	logic             need_rem;
	logic [CNT_W-1:0] seq_pos;
	logic [CNT_W-1:0] cnt_m1;
	logic [AMT_W:0]   jf_sum;
	logic [CNT_W-1:0] jump_pos;
	logic             jump_ok;

	// rebuild and draw
	logic [LFSR_W-1:0] lfsr_nx;
	logic [CNT_W:0]    p_sum;
	logic [CNT_W-1:0]  p_pick;
	logic              last_n;
	logic [CNT_W-1:0]  cur_clamp;
	logic [CNT_W-1:0]  cur_next;
	logic [CNT_W-1:0]  cfg_cnt;

	assign accept = start && !busy;
	assign cnt_m1 = cnt_q - 1'b1;
	assign is_step = command.cmd == CMD_FWD || command.cmd == CMD_BACK ||
		command.cmd == CMD_REPEAT;
	assign step_back = command.cmd == CMD_BACK || (command.cmd == CMD_REPEAT && back_q);
	assign table_mode = mode_q == MODE_RANDOM || mode_q == MODE_SHUFFLE;
	assign fwd_sum = {1'b0, pos_q} + 1'b1;
	assign back_dif = pos_q - 1'b1;

	// sequential step; position may sit past the count after it shrank
	always_comb begin
		need_rem = 1'b0;
		seq_pos = '0;
		rem_dividend = '0;
		if (!step_back) begin
			rem_dividend = fwd_sum[CNT_W-1:0];
			priority if (fwd_sum < {1'b0, cnt_q}) begin
				seq_pos = fwd_sum[CNT_W-1:0];
			end else if (fwd_sum == {1'b0, cnt_q}) begin
				seq_pos = '0;
			end else begin
				need_rem = 1'b1;
			end
		end else begin
			rem_dividend = back_dif;
			priority if (pos_q == '0) begin
				seq_pos = cnt_m1;
			end else if (pos_q <= cnt_q) begin
				seq_pos = back_dif;
			end else begin
				need_rem = 1'b1;
			end
		end
	end

	assign jf_sum = {{(AMT_W + 1 - CNT_W){1'b0}}, pos_q} + {1'b0, command.amount};

	always_comb begin
		jump_ok = 1'b1;
		jump_pos = pos_q;
		unique case (command.cmd)
			CMD_JUMP_FWD: begin
				jump_pos = (jf_sum > {{(AMT_W + 1 - CNT_W){1'b0}}, cnt_m1}) ?
					cnt_m1 : jf_sum[CNT_W-1:0];
			end
			CMD_JUMP_BACK: begin
				jump_pos = (command.amount > {{(AMT_W - CNT_W){1'b0}}, pos_q}) ?
					'0 : pos_q - command.amount[CNT_W-1:0];
			end
			CMD_JUMP_TO: begin
				if (command.amount == '0 ||
					command.amount > {{(AMT_W - CNT_W){1'b0}}, cnt_q}) begin
					jump_ok = 1'b0;
				end else begin
					jump_pos = command.amount[CNT_W-1:0] - 1'b1;
				end
			end
			default: begin
				jump_ok = 1'b0;
			end
		endcase
	end

	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

	// swap partner n + ((r * (count - n)) >> 16) always falls below count
	assign p_sum = {1'b0, n_q} + {1'b0, prod_q[PW-1:LFSR_W]};
	assign p_pick = (p_sum > {1'b0, cnt_m1}) ? cnt_m1 : p_sum[CNT_W-1:0];
	assign last_n = n_q == cnt_m1;

	assign cur_clamp = (cursor_q >= cnt_q) ? cnt_m1 : cursor_q;
	always_comb begin
		if (mode_q == MODE_SHUFFLE) begin
			if (dir_q) begin
				cur_next = (cur_clamp == cnt_m1) ? '0 : cur_clamp + 1'b1;
			end else begin
				cur_next = (cur_clamp == '0) ? cnt_m1 : cur_clamp - 1'b1;
			end
		end else begin
			cur_next = cur_clamp;
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			cfg_cnt = CNT_W'(1);
		end else if (int'(cfg_data) > MAX_ITEMS) begin
			cfg_cnt = CNT_W'(MAX_ITEMS);
		end else begin
			cfg_cnt = cfg_data;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && is_step) begin
					priority if (table_mode) begin
						state_d = valid_q ? ST_DRAW : ST_INIT;
					end else if (need_rem) begin
						state_d = ST_REM;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_INIT: state_d = last_n ? ST_MUL : ST_INIT;
			ST_MUL: state_d = ST_RD;
			ST_RD: state_d = ST_WA;
			ST_WA: state_d = ST_WB;
			ST_WB: state_d = last_n ? ST_DRAW : ST_MUL;
			ST_DRAW: state_d = ST_DATA;
			ST_DATA: state_d = ST_IDLE;
			ST_REM: state_d = rem_done ? ST_IDLE : ST_REM;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and divider controls
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = AW'(n_q);
		mem_wdata = AW'(n_q);
		mem_re = 1'b0;
		mem_raddr_a = AW'(n_q);
		mem_raddr_b = AW'(p_pick);
		rem_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rem_start = accept && is_step && !table_mode && need_rem;
			end
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_RD: begin
				mem_re = 1'b1;
			end
			ST_WA: begin
				mem_we = 1'b1;
				mem_wdata = mem_rdata_b;
			end
			ST_WB: begin
				mem_we = 1'b1;
				mem_waddr = AW'(p_q);
				mem_wdata = mem_rdata_a;
			end
			ST_DRAW: begin
				mem_re = 1'b1;
				mem_raddr_a = AW'(cur_next);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= CNT_W'(1);
			mode_q <= MODE_SEQ;
			pos_q <= '0;
			back_q <= 1'b0;
			dir_q <= 1'b0;
			valid_q <= 1'b0;
			cursor_q <= '0;
			lfsr_q <= LFSR_SEED;
			n_q <= '0;
			done_q <= 1'b0;
			acc_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q <= '0;
						if (is_step) begin
							dir_q <= step_back;
							acc_q <= 1'b1;
							if (command.cmd != CMD_REPEAT) begin
								back_q <= step_back;
							end
							if (!table_mode && !need_rem) begin
								pos_q <= seq_pos;
								done_q <= 1'b1;
							end
						end else begin
							pos_q <= jump_pos;
							acc_q <= jump_ok;
							done_q <= 1'b1;
						end
					end
				end
				ST_INIT: begin
					n_q <= last_n ? '0 : n_q + 1'b1;
				end
				ST_MUL: begin
					lfsr_q <= lfsr_nx;
				end
				ST_WB: begin
					if (last_n) begin
						cursor_q <= cnt_m1;
						valid_q <= 1'b1;
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				ST_DRAW: begin
					if (mode_q == MODE_SHUFFLE) begin
						cursor_q <= cur_next;
					end else if (cur_clamp == '0) begin
						cursor_q <= '0;
						valid_q <= 1'b0;
					end else begin
						cursor_q <= cur_clamp - 1'b1;
					end
				end
				ST_DATA: begin
					pos_q <= CNT_W'(mem_rdata_a);
					done_q <= 1'b1;
				end
				ST_REM: begin
					if (rem_done) begin
						pos_q <= rem_value;
						done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			// user keeps config idle-only, unchecked; count write drops table
			if (cfg_valid) begin
				if (cfg_index == REG_IMAGE_COUNT) begin
					cnt_q <= cfg_cnt;
					valid_q <= 1'b0;
				end else if (cfg_index == REG_ORDER_MODE) begin
					mode_q <= cfg_data[MODE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PW'(lfsr_nx) * PW'(cnt_q - n_q);
		end
		if (state_q == ST_RD) begin
			p_q <= p_pick;
		end
	end

	sin_order_mem #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	sin_urem #(
		.W(CNT_W)
	) u_urem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(rem_dividend),
		.divisor (cnt_q),
		.done    (rem_done),
		.rem     (rem_value)
	);

	assign busy = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign result_valid = done_q;
	assign result.current_position = pos_q[POS_W-1:0];
	assign result.accepted = acc_q;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || result_valid))
		else $error("transfer neither started work nor produced a result");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while sequencer still busy");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (cursor_q < cnt_q))
		else $error("draw cursor outside valid table");

	a_swap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WA || state_q == ST_WB) |-> (n_q < cnt_q && p_q < cnt_q && p_q >= n_q))
		else $error("swap indexes out of range");

	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("LFSR locked at zero");

endmodule
